// ===== hdl/sni_pkg.sv =====
// Shared constants, codes and types of the sorted node id table.
package sni_pkg;

	localparam int MAX_NODES = 16;
	localparam int ID_W      = 8;
	localparam int POS_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int INDEX_W   = 4;
	localparam int COUNT_W   = 5;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_RESET  = 2'd1,
		REQ_LOOKUP = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2,
		ST_ZERO = 2'd3
	} status_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic            ins;  // sorted insert of id
		logic            clr;  // empty the row, head cell takes id
		logic [ID_W-1:0] id;   // id under comparison
	} cell_cmd_t;

endpackage

// ===== hdl/sni_cell.sv =====
// One slot of the sorted id row: holds an id, compares, shifts from its left neighbor.
module sni_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sni_pkg::cell_cmd_t      cmd,
	input  logic                    head,     // leftmost cell
	input  logic                    left_lt,  // left neighbor holds an id below cmd.id
	input  logic [sni_pkg::ID_W-1:0] left_val,
	output logic                    lt,
	output logic                    eq,
	output logic                    at,       // first slot not below cmd.id
	output logic [sni_pkg::ID_W-1:0] val
);
	import sni_pkg::*;

	logic [ID_W-1:0] val_q;
	logic            used;

	assign used = (val_q != '0);
	assign lt   = used && (val_q < cmd.id);
	assign eq   = used && (val_q == cmd.id);
	assign at   = !lt && left_lt;
	assign val  = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (cmd.clr) begin
			val_q <= head ? cmd.id : '0;
		end else if (cmd.ins && !lt) begin
			// larger ids and free slots move up; the boundary slot takes the new id
			val_q <= at ? cmd.id : left_val;
		end
	end

endmodule

// ===== hdl/sni_row.sv =====
// Row of id cells with the position encoder over the boundary flags.
module sni_row (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sni_pkg::cell_cmd_t        cmd,
	output logic                      hit,
	output logic [sni_pkg::POS_W-1:0] pos
);
	import sni_pkg::*;

	logic [MAX_NODES-1:0] lt_w;
	logic [MAX_NODES-1:0] eq_w;
	logic [MAX_NODES-1:0] at_w;
	logic [ID_W-1:0]      val_w [MAX_NODES];

	for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
		if (i == 0) begin : g_head
			sni_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cmd),
				.head     (1'b1),
				.left_lt  (1'b1),
				.left_val ({ID_W{1'b0}}),
				.lt       (lt_w[i]),
				.eq       (eq_w[i]),
				.at       (at_w[i]),
				.val      (val_w[i])
			);
		end else begin : g_body
			sni_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cmd),
				.head     (1'b0),
				.left_lt  (lt_w[i-1]),
				.left_val (val_w[i-1]),
				.lt       (lt_w[i]),
				.eq       (eq_w[i]),
				.at       (at_w[i]),
				.val      (val_w[i])
			);
		end
	end

	assign hit = |eq_w;

	// boundary flag is one-hot (or empty when every slot is below the id)
	always_comb begin
		pos = '0;
		for (int i = 0; i < MAX_NODES; i++) begin
			if (at_w[i]) pos = pos | POS_W'(i);
		end
	end

endmodule

// ===== hdl/sorted_node_id_table.sv =====
// Top level of the sorted node id table: request stage, control and result register.
module sorted_node_id_table (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: own node id
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,   // own_node_id
	// requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // node_id[7:0]
	input  logic [1:0]  s_tuser,    // req_type[1:0]
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata     // status[1:0], found[2], index[6:3], count[11:7], zero[15:12]
);
	// The table keeps up to MAX_NODES node ids in ascending order, one per cell of a
	// row; a free slot holds zero. Request kinds on tuser: insert (0), reset list (1),
	// look up (2, and 3 acts as a look up). Every request gives one result item with
	// status (ok, duplicate, full, zero id), the found flag, the id's sorted position
	// (its matrix index, 0 when absent) and the count after the request. A reset
	// request empties the row and registers own_node_id; a hardware reset only empties
	// it and sets own_node_id to 1. A request waits in the request register while every
	// cell compares with it in parallel; on an insert the cells from the boundary on take
	// the new id or their left neighbor's id at the same edge that loads the result
	// register. The result register lets the next request be taken while a result waits;
	// a request stalls in the request register only while the previous result is still
	// held. cfg_ready is always high; write the own id only while the table is idle.
	import sni_pkg::*;

	logic             req_valid_s1;
	req_t             req_kind_s1;
	logic [ID_W-1:0]  req_id_s1;
	logic [ID_W-1:0]  own_id_q;
	logic [CNT_W-1:0] id_count_q;

	logic             out_valid_q;
	logic [15:0]      out_q;

	logic             go;
	logic             hit;
	logic [POS_W-1:0] pos;
	cell_cmd_t        cmd;

	logic             do_ins;
	logic             do_clr;
	status_t          status;
	logic             found;
	logic [INDEX_W-1:0] index;
	logic [CNT_W-1:0] cnt_nxt;
	logic             full;

	assign cfg_ready = 1'b1;
	assign s_tready  = !req_valid_s1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	assign go   = req_valid_s1 && (!out_valid_q || m_tready);
	assign full = (id_count_q == CNT_W'(MAX_NODES));

	// decision on the current request, from the row's compare results
	always_comb begin
		do_ins  = 1'b0;
		do_clr  = 1'b0;
		status  = ST_OK;
		found   = 1'b0;
		index   = '0;
		cnt_nxt = id_count_q;
		unique case (req_kind_s1)
			REQ_INSERT: begin
				if (req_id_s1 == '0) begin
					status = ST_ZERO;
				end else if (hit) begin
					status = ST_DUP;
					found  = 1'b1;
					index  = INDEX_W'(pos);
				end else if (full) begin
					status = ST_FULL;
				end else begin
					do_ins  = 1'b1;
					found   = 1'b1;
					index   = INDEX_W'(pos);
					cnt_nxt = id_count_q + CNT_W'(1);
				end
			end
			REQ_RESET: begin
				do_clr = 1'b1;
				if (own_id_q == '0) begin
					status  = ST_ZERO;
					cnt_nxt = '0;
				end else begin
					found   = 1'b1;
					cnt_nxt = CNT_W'(1);
				end
			end
			default: begin
				if (req_id_s1 == '0) begin
					status = ST_ZERO;
				end else begin
					found = hit;
					index = hit ? INDEX_W'(pos) : '0;
				end
			end
		endcase
	end

	assign cmd.ins = go && do_ins;
	assign cmd.clr = go && do_clr;
	assign cmd.id  = (req_kind_s1 == REQ_RESET) ? own_id_q : req_id_s1;

	sni_row u_row (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.hit    (hit),
		.pos    (pos)
	);

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			req_valid_s1 <= 1'b1;
		end else if (go) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_kind_s1 <= req_t'(s_tuser);
			req_id_s1   <= s_tdata;
		end
	end

	// own id and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q   <= ID_W'(1);
			id_count_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) own_id_q <= cfg_data;
			if (go) id_count_q <= cnt_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_q <= {4'd0, COUNT_W'(cnt_nxt), index, found, status};
		end
	end

endmodule

// ===== verif/sni_checker.sv =====
// Checker for the sorted node id table: tracks the id list, predicts each result and compares.
module sni_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	output int          errors,
	output int          pending
);
	import sni_pkg::*;

	typedef struct packed {
		status_t    status;
		logic       found;
		logic [3:0] index;
		logic [4:0] count;
	} node_result_t;

	logic [7:0]   own_id;
	logic [7:0]   ids [MAX_NODES];
	int unsigned  held;
	node_result_t awaited [$];
	node_result_t want;

	initial errors = 0;
	initial pending = 0;

	// position of id among held entries, -1 when absent
	function automatic int locate_id(logic [7:0] id);
		for (int i = 0; i < held && i < MAX_NODES; i++) begin
			if (ids[i] == id)
				return i;
		end
		return -1;
	endfunction

	function automatic status_t place_id(logic [7:0] id);
		int p;
		if (id == 8'd0)
			return ST_ZERO;
		if (locate_id(id) >= 0)
			return ST_DUP;
		if (held >= MAX_NODES)
			return ST_FULL;
		p = 0;
		while (p < held && ids[p] < id)
			p++;
		for (int k = held; k > p; k--)
			ids[k] = ids[k-1];
		ids[p] = id;
		held++;
		return ST_OK;
	endfunction

	function automatic node_result_t serve_request(logic [1:0] req, logic [7:0] id);
		node_result_t r;
		int pos;
		case (req)
			REQ_INSERT: begin
				r.status = place_id(id);
			end
			REQ_RESET: begin
				foreach (ids[i])
					ids[i] = 8'd0;
				held = 0;
				id = own_id;
				r.status = place_id(id);
			end
			default: begin
				// lookup, and the spare code behaves as one
				r.status = (id == 8'd0) ? ST_ZERO : ST_OK;
			end
		endcase
		pos = (id == 8'd0) ? -1 : locate_id(id);
		r.found = (pos >= 0);
		r.index = (pos >= 0) ? pos[3:0] : 4'd0;
		r.count = held[4:0];
		return r;
	endfunction

	function automatic int field_bad(string name, logic [15:0] exp_v, logic [15:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (ids[i])
				ids[i] = 8'd0;
			held = 0;
			own_id = 8'd1;
			awaited.delete();
		end else begin
			// results first, so a stray result never pairs with an item taken at this edge
			if (m_tvalid && m_tready) begin
				if (awaited.size() == 0) begin
					$error("result 0x%h with no request outstanding", m_tdata);
					errors++;
				end else begin
					want = awaited.pop_front();
					errors += field_bad("status", 16'(want.status), 16'(m_tdata[1:0]));
					errors += field_bad("found", 16'(want.found), 16'(m_tdata[2]));
					errors += field_bad("index", 16'(want.index), 16'(m_tdata[6:3]));
					errors += field_bad("count", 16'(want.count), 16'(m_tdata[11:7]));
					errors += field_bad("pad", 16'd0, 16'(m_tdata[15:12]));
				end
			end
			if (cfg_valid && cfg_ready)
				own_id = cfg_data;
			if (s_tvalid && s_tready)
				awaited.push_back(serve_request(s_tuser, s_tdata));
		end
		pending = awaited.size();
	end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the sorted node id table: reset, stimulus, flow control and verdict.
module tb;
	import sni_pkg::*;

	// unused request code, the block treats it as a lookup
	localparam logic [1:0] REQ_SPARE = 2'd3;
	// quiet time after draining before a register write or the verdict
	localparam int DRAIN_CYCLES = 4 * MAX_NODES;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 244;

	typedef enum int {
		IDLE_NONE,
		IDLE_SRC,
		IDLE_SINK,
		IDLE_BOTH
	} stall_mode_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // node_id[7:0]
	logic [1:0]  s_tuser;    // req_type[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;    // status[1:0], found[2], index[6:3], count[11:7], zero[15:12]

	int          errors;
	int          pending;
	stall_mode_t mode;
	logic [7:0]  own_now;    // own id as last written, used only to seed the pool of insert and lookup ids

	sorted_node_id_table uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	sni_checker scb (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop: far beyond the time that ~2000 items need even with heavy stalls
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side back-pressure, redrawn every cycle
	always @(posedge clk) begin
		case (mode)
			IDLE_SINK: m_tready <= ($urandom_range(0, 99) >= 45);
			IDLE_BOTH: m_tready <= ($urandom_range(0, 99) >= 12);
			default:   m_tready <= 1'b1;
		endcase
	end

	// sender gap decision for the next cycle
	function automatic bit src_pause();
		case (mode)
			IDLE_SRC:  return ($urandom_range(0, 99) < 45);
			IDLE_BOTH: return ($urandom_range(0, 99) < 12);
			default:   return 1'b0;
		endcase
	endfunction

	// Present one item and hold it until the block takes it. Valid stays high
	// straight into the next item unless a gap is drawn.
	task automatic send_req(input logic [1:0] req, input logic [7:0] id);
		while (src_pause()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= id;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Wait for every outstanding result, then give the block time to go quiet.
	task automatic settle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_own_id(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		own_now = v;
	endtask

	// Mostly well-formed sessions: a list reset, then a burst of inserts with
	// lookups sprinkled in. Long bursts fill the list and hit the full case.
	// The rest is unstructured noise over all request codes.
	task automatic random_phase(input int quota);
		int         sent;
		int         n;
		int         roll;
		logic [7:0] id;
		logic [1:0] kind;
		logic [7:0] pool [$];
		sent = 0;
		while (sent < quota) begin
			roll = $urandom_range(0, 99);
			if (roll < 85) begin
				send_req(REQ_RESET, 8'($urandom));
				sent++;
				pool.delete();
				if (own_now != 8'd0)
					pool.push_back(own_now);
				n = $urandom_range(0, 18);
				repeat (n) begin
					roll = $urandom_range(0, 99);
					if (roll < 3)
						id = 8'd0;
					else if (roll < 13 && pool.size() > 0)
						id = pool[$urandom_range(0, pool.size() - 1)];
					else
						id = 8'($urandom_range(1, 255));
					send_req(REQ_INSERT, id);
					sent++;
					if (id != 8'd0)
						pool.push_back(id);
					if ($urandom_range(0, 99) < 35) begin
						if ($urandom_range(0, 99) < 60 && pool.size() > 0)
							id = pool[$urandom_range(0, pool.size() - 1)];
						else
							id = 8'($urandom);
						kind = ($urandom_range(0, 9) == 0) ? REQ_SPARE : REQ_LOOKUP;
						send_req(kind, id);
						sent++;
					end
				end
			end else begin
				repeat ($urandom_range(1, 6)) begin
					send_req(2'($urandom_range(0, 3)), 8'($urandom));
					sent++;
				end
			end
		end
	endtask

	initial begin
		logic [7:0] own;
		// every input known from time zero
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = 8'd0;
		s_tvalid  = 1'b0;
		s_tdata   = 8'd0;
		s_tuser   = REQ_INSERT;
		m_tready  = 1'b0;
		mode      = IDLE_NONE;
		own_now   = 8'd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, zero id, extremes, duplicate, spare code,
		// reset request with ignored id, fill to full, full reject
		send_req(REQ_LOOKUP, 8'd5);
		send_req(REQ_LOOKUP, 8'd0);
		send_req(REQ_INSERT, 8'd0);
		send_req(REQ_INSERT, 8'd255);
		send_req(REQ_INSERT, 8'd1);
		send_req(REQ_INSERT, 8'd128);
		send_req(REQ_INSERT, 8'd128);
		send_req(REQ_LOOKUP, 8'd255);
		send_req(REQ_SPARE, 8'd1);
		send_req(REQ_RESET, 8'd200);
		// descending ids all land just behind own id 1 and shift the rest of the row
		for (int k = 0; k < MAX_NODES - 1; k++)
			send_req(REQ_INSERT, 8'(250 - 16 * k));
		send_req(REQ_INSERT, 8'd2);
		send_req(REQ_LOOKUP, 8'd250);
		settle();

		// random phases: idle pattern cycles through none, sender, receiver,
		// both; own id steps through both extremes, zero, the midpoint and random values
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       own = 8'd255;
				1:       own = 8'd1;
				2:       own = 8'd0;
				4:       own = 8'd128;
				6:       own = 8'd255;
				default: own = 8'($urandom_range(1, 255));
			endcase
			write_own_id(own);
			mode = stall_mode_t'(ph % 4);
			random_phase(PHASE_ITEMS);
			settle();
		end

		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/sni_pkg.sv
hdl/sni_cell.sv
hdl/sni_row.sv
hdl/sorted_node_id_table.sv
verif/sni_checker.sv
verif/tb.sv
